@@ hdl/lkrc_pkg.sv @@
package lkrc_pkg;

  // Beat field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned HandleW = 32;
  localparam int unsigned BlenW   = 24;
  localparam int unsigned TcountW = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned StampW  = 48;
  localparam int unsigned CapW    = 10;

  // Packed stream words, padded to whole bytes
  localparam int unsigned InDataW  = 176;
  localparam int unsigned OutDataW = 176;

  // Entry data word: byte handle, token handle, byte length, token count
  localparam int unsigned EntryDataW = 2 * HandleW + BlenW + TcountW;

  // Register map
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned RegCapAddr = 0;

  typedef enum logic [OpW-1:0] {
    OP_PUT        = 2'd0,
    OP_LOOKUP_BYT = 2'd1,
    OP_LOOKUP_TOK = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_MISS    = 3'd0,
    ST_HIT     = 3'd1,
    ST_NEW     = 3'd2,
    ST_UPDATED = 3'd3,
    ST_EVICTED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [TcountW-1:0] tcount;
    logic [BlenW-1:0]   blen;
    logic [HandleW-1:0] thandle;
    logic [HandleW-1:0] bhandle;
  } entry_data_t;

endpackage

@@ hdl/lru_keyed_replay_cache.sv @@
// Fully associative key cache with least-recently-used replacement.
// Each entry maps a nonzero 64-bit key to a byte payload (handle, length) and
// a token array (handle, count). Keys and use stamps sit side by side in one
// synchronous memory that is scanned in index order; the payload sits in a
// second memory that is read at the matched slot. One operation is in flight
// at a time. From one accept to the next an item goes through the accept, one
// read per used entry, taking in the last read and closing the scan, a payload
// fetch and a write-back. The scan over the key/stamp memory port grows with
// the number of used entries and sets the time per item. Rejected items (zero
// key, put without byte payload, opcode 3) skip the scan and the payload
// fetch and go straight to the response. The result register is
// separate, so a finished result can wait for the consumer while the block
// returns to idle; the next item then waits in its write-back cycle until that
// beat is taken. capacity (byte address 0) saturates to ENTRIES; a written
// zero also means ENTRIES. Lowering capacity below the number of used entries
// drops nothing; new keys then evict among all used entries. The use clock
// wraps modulo 2^48. No clearing pass after reset: only entries below the fill
// count are ever read.
module lru_keyed_replay_cache
  import lkrc_pkg::*;
#(
  parameter int unsigned ENTRIES = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: opcode[1:0], key[65:2], byte_present[66], byte_handle[98:67],
  //        byte_len[122:99], token_handle[154:123], token_count[170:155], pad
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tdata: status[2:0], out_byte_handle[34:3], out_byte_len[58:35],
  //        out_token_handle[90:59], out_token_count[106:91],
  //        evicted_key[170:107], pad
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  // ---------------------------------------------------------------- config
  logic [CW-1:0]   cap_q;
  logic [CapW-1:0] cfg_val;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign cfg_val = pwdata[CapW-1:0];
  assign cfg_wr  = psel && penable && pwrite && (paddr == CfgAddrW'(RegCapAddr));
  assign prdata  = {{(32 - CW){1'b0}}, cap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(ENTRIES);
    end else if (cfg_wr) begin
      if ((cfg_val == '0) || (32'(cfg_val) > 32'(ENTRIES))) begin
        cap_q <= CW'(ENTRIES);
      end else begin
        cap_q <= CW'(cfg_val);
      end
    end
  end

  // ---------------------------------------------------------------- input
  logic        in_fire;
  op_e         in_op;
  logic [KeyW-1:0] in_key;
  logic        in_bpres;
  entry_data_t in_data;

  assign in_fire          = s_axis_tvalid && s_axis_tready;
  assign in_op            = op_e'(s_axis_tdata[1:0]);
  assign in_key           = s_axis_tdata[65:2];
  assign in_bpres         = s_axis_tdata[66];
  assign in_data.bhandle  = s_axis_tdata[98:67];
  assign in_data.blen     = s_axis_tdata[122:99];
  assign in_data.tcount   = s_axis_tdata[170:155];
  // an empty token array (count zero) stores a zero handle
  assign in_data.thandle  = (s_axis_tdata[170:155] == '0) ? '0 : s_axis_tdata[154:123];

  // ---------------------------------------------------------------- state
  fsm_e            state_q, state_d;
  op_e             op_q;
  logic [KeyW-1:0] key_q;
  entry_data_t     wdata_q;
  logic            rej_q, rej_d;
  logic [CW-1:0]   used_q, used_d;
  logic [StampW-1:0] clock_q, clock_d;

  // scan bookkeeping
  logic [CW-1:0]     scan_addr_q, scan_addr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic              hit_q, hit_d;
  logic [IW-1:0]     slot_q, slot_d;
  logic [IW-1:0]     lru_q, lru_d;
  logic [StampW-1:0] lru_stamp_q, lru_stamp_d;
  logic [KeyW-1:0]   lru_key_q, lru_key_d;

  // memories: tag word is {stamp, key}
  logic [StampW+KeyW-1:0] tag_mem  [ENTRIES];
  logic [EntryDataW-1:0]  data_mem [ENTRIES];
  logic [StampW+KeyW-1:0] tag_rd_q;
  logic [KeyW-1:0]        key_rd;
  logic [StampW-1:0]      stamp_rd;
  entry_data_t            data_rd_q;
  logic [IW-1:0]          scan_idx;
  logic [IW-1:0]          wr_idx;
  logic                   stamp_we, data_we;

  // result register
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  assign scan_idx = scan_addr_q[IW-1:0];
  assign key_rd   = tag_rd_q[KeyW-1:0];
  assign stamp_rd = tag_rd_q[StampW+KeyW-1:KeyW];

  // key rides along with every stamp write; on a hit it equals the stored key
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      tag_mem[wr_idx] <= {clock_d, key_q};
    end
    tag_rd_q <= tag_mem[scan_idx];
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[wr_idx] <= wdata_q;
    end
    data_rd_q <= data_mem[slot_q];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    logic          resp_go;
    logic [StatusW-1:0]  r_status;
    logic [HandleW-1:0]  r_bh, r_th;
    logic [BlenW-1:0]    r_bl;
    logic [TcountW-1:0]  r_tc;
    logic [KeyW-1:0]     r_ev;

    state_d     = state_q;
    rej_d       = rej_q;
    used_d      = used_q;
    clock_d     = clock_q;
    scan_addr_d = scan_addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    slot_d      = slot_q;
    lru_d       = lru_q;
    lru_stamp_d = lru_stamp_q;
    lru_key_d   = lru_key_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    stamp_we    = 1'b0;
    data_we     = 1'b0;
    wr_idx      = slot_q;
    resp_go     = 1'b0;
    r_status    = ST_MISS;
    r_bh        = '0;
    r_bl        = '0;
    r_th        = '0;
    r_tc        = '0;
    r_ev        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          hit_d       = 1'b0;
          scan_addr_d = '0;
          rej_d = (in_key == '0) || (in_op == OP_NONE) || ((in_op == OP_PUT) && !in_bpres);
          state_d = rej_d ? S_RESP : S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one key/stamp read per cycle, process the previous one
        if (scan_addr_q < used_q) begin
          rd_vld_d    = 1'b1;
          rd_idx_d    = scan_idx;
          scan_addr_d = scan_addr_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (!hit_q && (key_rd == key_q)) begin
            hit_d  = 1'b1;
            slot_d = rd_idx_q;
          end
          // strict less keeps the lowest index on equal stamps
          if ((rd_idx_q == '0) || (stamp_rd < lru_stamp_q)) begin
            lru_d       = rd_idx_q;
            lru_stamp_d = stamp_rd;
            lru_key_d   = key_rd;
          end
        end
        if ((scan_addr_q >= used_q) && !rd_vld_q) begin
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        // payload read at slot_q lands in data_rd_q
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          resp_go = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (resp_go && !rej_q) begin
      unique case (op_q)
        OP_PUT: begin
          data_we  = 1'b1;
          stamp_we = 1'b1;
          clock_d  = clock_q + 1'b1;
          if (hit_q) begin
            r_status = ST_UPDATED;
          end else if (used_q < cap_q) begin
            r_status = ST_NEW;
            wr_idx   = used_q[IW-1:0];
            used_d   = used_q + 1'b1;
          end else begin
            r_status = ST_EVICTED;
            wr_idx   = lru_q;
            r_ev     = lru_key_q;
          end
        end
        OP_LOOKUP_BYT: begin
          if (hit_q) begin
            r_status = ST_HIT;
            r_bh     = data_rd_q.bhandle;
            r_bl     = data_rd_q.blen;
            stamp_we = 1'b1;
            clock_d  = clock_q + 1'b1;
          end
        end
        OP_LOOKUP_TOK: begin
          if (hit_q && (data_rd_q.tcount != '0)) begin
            r_status = ST_HIT;
            r_bl     = data_rd_q.blen;
            r_th     = data_rd_q.thandle;
            r_tc     = data_rd_q.tcount;
            stamp_we = 1'b1;
            clock_d  = clock_q + 1'b1;
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end

    if (resp_go) begin
      m_valid_d = 1'b1;
      m_data_d  = {5'b0, r_ev, r_tc, r_th, r_bl, r_bh, r_status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rej_q     <= 1'b0;
      used_q    <= '0;
      clock_q   <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rej_q     <= rej_d;
      used_q    <= used_d;
      clock_q   <= clock_d;
      rd_vld_q  <= rd_vld_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= in_op;
      key_q   <= in_key;
      wdata_q <= in_data;
    end
    scan_addr_q <= scan_addr_d;
    rd_idx_q    <= rd_idx_d;
    slot_q      <= slot_d;
    lru_q       <= lru_d;
    lru_stamp_q <= lru_stamp_d;
    lru_key_q   <= lru_key_d;
    m_data_q    <= m_data_d;
  end

endmodule
